FILE: design/ratio_test_step_length_macros.svh
// ----------------------------------------------------------------------------
// ratio_test_step_length assertion macros
// shared concurrent assertion forms for the step length checker
// ----------------------------------------------------------------------------
`ifndef RATIO_TEST_STEP_LENGTH_MACROS_SVH
`define RATIO_TEST_STEP_LENGTH_MACROS_SVH

// same-cycle implication, off during reset
`define RTSL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define RTSL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always checked
`define RTSL_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rtsl_pkg.sv
// ----------------------------------------------------------------------------
// rtsl_pkg
// types and constants of the fraction-to-boundary step length block
// ----------------------------------------------------------------------------
package rtsl_pkg;

    localparam int VALUE_W = 32;
    localparam int ALPHA_W = 16;
    localparam int STEP_W  = 17;
    localparam int NUM_W   = 47;
    localparam int CNT_W   = 5;

    localparam logic [STEP_W-1:0]  STEP_ONE    = 17'h10000;
    localparam logic [STEP_W-1:0]  STEP_ZERO   = 17'h00000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd64881;

    localparam logic [CNT_W-1:0] MUL_LAST = 5'd15;
    localparam logic [CNT_W-1:0] DIV_LAST = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_CMP,
        ST_FIN
    } state_t;

endpackage

FILE: design/ratio_test_step_length.sv
// ----------------------------------------------------------------------------
// ratio_test_step_length
// fraction-to-boundary ratio test over a stream of (value, direction) pairs
// a pair with non-negative direction or trivial candidate goes straight to the
// finish state; one whose candidate does not fit the 17-bit quotient skips the
// divide; any other needs both the bit-serial 16-bit multiply and 17-bit divide
// one pair in flight at a time; a result enters the output register, once
// free, at the end of its last pair and the next pair is taken while it waits
// synchronous active-low reset: alpha = 64881, running step = 1.0, no result
// ----------------------------------------------------------------------------
module ratio_test_step_length (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,    // damping_factor
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,        // current_value [31:0], direction_value [63:32]
    input  logic        s_tlast,        // last_element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata         // step_length [16:0], zero [23:17]
);

    rtsl_pkg::state_t state_reg, state_next;

    logic [rtsl_pkg::ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [rtsl_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [rtsl_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [30:0]                  mcand_reg, mcand_next;
    logic [rtsl_pkg::NUM_W-1:0]   acc_reg, acc_next;
    logic [31:0]                  den_reg, den_next;
    logic [31:0]                  rem_reg, rem_next;
    logic [rtsl_pkg::STEP_W-1:0]  dq_reg, dq_next;
    logic                         last_reg, last_next;
    logic                         m_valid_reg, m_valid_next;
    logic [rtsl_pkg::STEP_W-1:0]  m_data_reg, m_data_next;

    logic        s_fire;
    logic        neg_dir;
    logic        trivial;
    logic        out_load;
    logic        ovf;
    logic [31:0] mul_sum;
    logic [31:0] rem_init;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign s_fire   = s_tvalid && s_tready;
    assign neg_dir  = s_tdata[63];
    assign trivial  = s_tdata[31] || (s_tdata[30:0] == 31'd0) || (alpha_reg == 16'd0);
    assign out_load = (state_reg == rtsl_pkg::ST_FIN) && last_reg &&
                      (!m_valid_reg || m_tready);

    assign mul_sum  = {1'b0, acc_reg[46:16]} + (acc_reg[0] ? {1'b0, mcand_reg} : 32'd0);
    assign rem_init = {2'b00, acc_reg[46:17]};
    assign ovf      = rem_init >= den_reg;
    assign trial    = {rem_reg, dq_reg[16]};
    assign diff     = trial - {1'b0, den_reg};
    assign ge       = trial >= {1'b0, den_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rtsl_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (!neg_dir || trivial) begin
                        state_next = rtsl_pkg::ST_FIN;
                    end else begin
                        state_next = rtsl_pkg::ST_MUL;
                    end
                end
            end
            rtsl_pkg::ST_MUL: begin
                if (cnt_reg == rtsl_pkg::MUL_LAST) begin
                    state_next = rtsl_pkg::ST_CHK;
                end
            end
            rtsl_pkg::ST_CHK: begin
                state_next = ovf ? rtsl_pkg::ST_FIN : rtsl_pkg::ST_DIV;
            end
            rtsl_pkg::ST_DIV: begin
                if (cnt_reg == rtsl_pkg::DIV_LAST) begin
                    state_next = rtsl_pkg::ST_CMP;
                end
            end
            rtsl_pkg::ST_CMP: begin
                state_next = rtsl_pkg::ST_FIN;
            end
            rtsl_pkg::ST_FIN: begin
                if (!last_reg || out_load) begin
                    state_next = rtsl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rtsl_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_tready     = (state_reg == rtsl_pkg::ST_IDLE);
        alpha_next   = cfg_wr_en ? cfg_wr_data : alpha_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        mcand_next   = mcand_reg;
        acc_next     = acc_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            rtsl_pkg::ST_IDLE: begin
                if (s_fire) begin
                    last_next  = s_tlast;
                    mcand_next = s_tdata[30:0];
                    den_next   = ~s_tdata[63:32] + 32'd1;
                    acc_next   = {31'd0, alpha_reg};
                    cnt_next   = '0;
                    if (neg_dir && trivial) begin
                        step_next = rtsl_pkg::STEP_ZERO;
                    end
                end
            end
            rtsl_pkg::ST_MUL: begin
                acc_next = {mul_sum, acc_reg[15:1]};
                cnt_next = cnt_reg + 5'd1;
            end
            rtsl_pkg::ST_CHK: begin
                rem_next = rem_init;
                dq_next  = acc_reg[16:0];
                cnt_next = '0;
            end
            rtsl_pkg::ST_DIV: begin
                rem_next = ge ? diff[31:0] : trial[31:0];
                dq_next  = {dq_reg[15:0], ge};
                cnt_next = cnt_reg + 5'd1;
            end
            rtsl_pkg::ST_CMP: begin
                if (dq_reg < step_reg) begin
                    step_next = dq_reg;
                end
            end
            rtsl_pkg::ST_FIN: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_data_next  = (step_reg > rtsl_pkg::STEP_ONE) ? rtsl_pkg::STEP_ONE
                                                                    : step_reg;
                    step_next    = rtsl_pkg::STEP_ONE;
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rtsl_pkg::ST_IDLE;
            alpha_reg   <= rtsl_pkg::ALPHA_RESET;
            step_reg    <= rtsl_pkg::STEP_ONE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            alpha_reg   <= alpha_next;
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        dq_reg     <= dq_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

endmodule

FILE: design/rtsl_checker.sv
// ----------------------------------------------------------------------------
// rtsl_checker
// port-level checks of the fraction-to-boundary step length block
// ----------------------------------------------------------------------------
`include "ratio_test_step_length_macros.svh"

module rtsl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    `RTSL_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `RTSL_ASSERT_IMP(a_step_range, m_tvalid, m_tdata[16:0] <= rtsl_pkg::STEP_ONE, "step above one")
    `RTSL_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[23:17] == 7'd0, "padding bits set")
    `RTSL_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after a transaction")
    `RTSL_ASSERT_RST(a_reset_idle, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind ratio_test_step_length rtsl_checker u_rtsl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
